// ===== src/mexp_pkg.sv =====
`default_nettype none

package mexp_pkg;

  // Modulus and result width, fixed by the register definition.
  localparam int unsigned MOD_W = 62;
  localparam logic [MOD_W-1:0] MOD_RESET = 62'd1000000007;

  // Result stream payload, rounded up to whole bytes.
  localparam int unsigned OUT_TDATA_W = ((MOD_W + 7) / 8) * 8;

  // Configuration port.
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MODULUS = 4'h0;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_REDUCE  = 6'b000010,
    ST_EXP     = 6'b000100,
    ST_MUL_RES = 6'b001000,
    ST_MUL_SQR = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_e;

  // Selects the multiplicand when a modular product starts.
  typedef enum logic {
    MUL_RES = 1'b0,
    MUL_SQR = 1'b1
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     red_step;
    logic     red_end;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     mul_step;
    logic     res_wr;
    logic     sqr_wr;
    logic     out_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic mod_zero;
    logic red_done;
    logic mul_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/mexp_dp.sv =====
`default_nettype none

module mexp_dp #(
  parameter int unsigned OPERAND_BITS = 63
) (
  input  wire logic                         clk_i,
  input  wire mexp_pkg::dp_cmd_t            cmd_i,
  output mexp_pkg::dp_status_t              status_o,
  input  wire logic [OPERAND_BITS-1:0]      base_i,
  input  wire logic [OPERAND_BITS-1:0]      exponent_i,
  input  wire logic [mexp_pkg::MOD_W-1:0]   modulus_i,
  output logic      [mexp_pkg::MOD_W-1:0]   power_result_o
);
  import mexp_pkg::*;

  localparam int unsigned CNT_W = $clog2(OPERAND_BITS + 1);

  logic [MOD_W-1:0]        m_q;
  logic [OPERAND_BITS-1:0] e_q;
  logic [OPERAND_BITS-1:0] raw_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [MOD_W-1:0]        b_q;
  logic [MOD_W-1:0]        res_q;
  logic [MOD_W-1:0]        acc_q;
  logic [MOD_W-1:0]        dbl_q;
  logic [MOD_W-1:0]        mplr_q;
  logic [MOD_W-1:0]        out_q;

  logic [MOD_W:0]   mod_ext;
  logic [MOD_W:0]   red_ext;
  logic [MOD_W-1:0] red_next;
  logic [MOD_W:0]   sum_ext;
  logic [MOD_W-1:0] acc_next;
  logic [MOD_W:0]   dbl_ext;
  logic [MOD_W-1:0] dbl_next;

  // Every partial value stays below the modulus, so one conditional
  // subtraction brings a sum or a doubling back into range.
  always_comb begin
    mod_ext  = {1'b0, m_q};
    red_ext  = {acc_q, raw_q[OPERAND_BITS-1]};
    red_next = (red_ext >= mod_ext) ? MOD_W'(red_ext - mod_ext) : MOD_W'(red_ext);
    sum_ext  = {1'b0, acc_q} + {1'b0, dbl_q};
    acc_next = (sum_ext >= mod_ext) ? MOD_W'(sum_ext - mod_ext) : MOD_W'(sum_ext);
    dbl_ext  = {dbl_q, 1'b0};
    dbl_next = (dbl_ext >= mod_ext) ? MOD_W'(dbl_ext - mod_ext) : MOD_W'(dbl_ext);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q   <= modulus_i;
      e_q   <= exponent_i;
      raw_q <= base_i;
      acc_q <= '0;
      cnt_q <= CNT_W'(OPERAND_BITS);
      res_q <= (exponent_i == '0) ? MOD_W'(1) : '0;
    end
    if (cmd_i.red_step) begin
      acc_q <= red_next;
      raw_q <= raw_q << 1;
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.red_end) begin
      b_q   <= acc_q;
      res_q <= (m_q == MOD_W'(1)) ? '0 : MOD_W'(1);
    end
    if (cmd_i.res_wr) begin
      res_q <= acc_q;
    end
    if (cmd_i.sqr_wr) begin
      b_q <= acc_q;
      e_q <= e_q >> 1;
    end
    if (cmd_i.mul_step) begin
      if (mplr_q[0]) begin
        acc_q <= acc_next;
      end
      dbl_q  <= dbl_next;
      mplr_q <= mplr_q >> 1;
    end
    if (cmd_i.mul_start) begin
      acc_q  <= '0;
      dbl_q  <= (cmd_i.mul_sel == MUL_RES) ? res_q : b_q;
      mplr_q <= b_q;
    end
    if (cmd_i.out_wr) begin
      out_q <= res_q;
    end
  end

  always_comb begin
    status_o.exp_zero = (e_q == '0);
    status_o.exp_lsb  = e_q[0];
    status_o.mod_zero = (m_q == '0);
    status_o.red_done = (cnt_q == '0);
    status_o.mul_done = (mplr_q == '0);
  end

  assign power_result_o = out_q;

endmodule

`default_nettype wire

// ===== src/mexp_ctrl.sv =====
`default_nettype none

module mexp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire mexp_pkg::dp_status_t status_i,
  output mexp_pkg::dp_cmd_t         cmd_o
);
  import mexp_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_RES;
    out_valid_d   = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        priority if (status_i.exp_zero || status_i.mod_zero) begin
          state_d = ST_FINISH;
        end else if (status_i.red_done) begin
          cmd_o.red_end = 1'b1;
          state_d       = ST_EXP;
        end else begin
          cmd_o.red_step = 1'b1;
        end
      end
      ST_EXP: begin
        priority if (status_i.exp_zero) begin
          state_d = ST_FINISH;
        end else if (status_i.exp_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_RES;
          state_d         = ST_MUL_RES;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_SQR;
          state_d         = ST_MUL_SQR;
        end
      end
      ST_MUL_RES: begin
        if (status_i.mul_done) begin
          cmd_o.res_wr    = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_SQR;
          state_d         = ST_MUL_SQR;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      ST_MUL_SQR: begin
        if (status_i.mul_done) begin
          cmd_o.sqr_wr = 1'b1;
          state_d      = ST_EXP;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_wr = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/modular_exponentiation_top.sv =====
// Modular exponentiation: power_result = base ** exponent mod modulus.
//
// Input stream (s_axis_*): one item carries base and exponent. Result stream
// (m_axis_*): one item per input item, in order. The modulus is written over
// the APB-style port at byte address 0 (64-bit data, low 62 bits used) and
// must only be changed while the block is idle. It resets to 1000000007.
//
// One item is worked on at a time. The base is first reduced one bit per
// cycle. Each exponent bit, from the least significant up, costs a test,
// a squaring and, when set, a multiply into the running result. A modular
// product retires one multiplier bit per cycle until the multiplier is
// exhausted and then closes; below a 62-bit modulus the multiplier has at
// most 62 bits. Once the result is written to the output register the block
// returns to idle and takes the next item. A zero exponent or modulus skips
// the reduction and goes straight to the finishing step.
//
// Reset clears the controller and drops m_axis_tvalid. A finished result sits
// in an output register, so the next item is accepted while the receiver
// stalls; a second result waits inside the block until that register frees.
`default_nettype none

module modular_exponentiation_top #(
  parameter int unsigned OPERAND_BITS = 63
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Input stream.
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // Fields from bit 0: base, exponent (OPERAND_BITS each), zero fill.
  input  wire logic [((2*OPERAND_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // Result stream.
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // Fields from bit 0: power_result (62 bits), zero fill.
  output logic [mexp_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
  // Configuration port.
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [mexp_pkg::CFG_ADDR_W-1:0]       paddr,
  input  wire logic [mexp_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic      [mexp_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                       pready
);
  import mexp_pkg::*;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [MOD_W-1:0] modulus_q;
  logic [MOD_W-1:0] power_result;

  // Modulus register; written in the access phase of an APB write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_MODULUS)) begin
      modulus_q <= pwdata[MOD_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MODULUS) ? CFG_DATA_W'(modulus_q) : '0;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mexp_dp #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .base_i         (s_axis_tdata[OPERAND_BITS-1:0]),
    .exponent_i     (s_axis_tdata[2*OPERAND_BITS-1:OPERAND_BITS]),
    .modulus_i      (modulus_q),
    .power_result_o (power_result)
  );

  assign m_axis_tdata = OUT_TDATA_W'(power_result);

endmodule

`default_nettype wire

// ===== src/mexp_checker.sv =====
`default_nettype none

module mexp_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [mexp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import mexp_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Items accepted whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("new item accepted while previous item still in work");

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 2'd0)
    else $error("result delivered without a pending item");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q == 2'd0 || pend_q == 2'd1)
    else $error("more than one result held back inside the block");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:MOD_W] == '0)
    else $error("result fill bits not zero");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (.*);

`default_nettype wire

// ===== bench/tb_modular_exponentiation_top.sv =====
module tb_modular_exponentiation_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mexp_pkg::*;

  // The block is built for full 63-bit operands; the input item packs base
  // and exponent side by side and pads them to 128 bits.
  localparam int unsigned OPERAND_BITS = 63;
  localparam int unsigned IN_TDATA_W   = ((2 * OPERAND_BITS + 7) / 8) * 8;

  // The run sends about 100 items, each at worst a full-length exponentiation,
  // so a correct run stays well inside the watchdog limit.
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned RANDOM_PHASES    = 5;
  localparam int unsigned ITEMS_PER_PHASE  = 16;
  localparam int unsigned DIRECTED_ROWS    = 22;
  localparam int unsigned MAX_REPORTS      = 10;

  // Receiver behaviour; a new mode is drawn at random when the current one runs out.
  typedef enum int unsigned {
    READY_ALWAYS  = 0,
    READY_COIN    = 1,
    READY_PATTERN = 2
  } ready_mode_e;

  // One row of the directed table. A row may first load a new modulus; where
  // the result is obvious by inspection it is typed in, otherwise the
  // predictor supplies it.
  typedef struct packed {
    bit                    load_modulus;
    bit [MOD_W-1:0]        modulus;
    bit [OPERAND_BITS-1:0] base;
    bit [OPERAND_BITS-1:0] exponent;
    bit                    typed_in;
    bit [MOD_W-1:0]        power;
  } directed_row_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // Fields from bit 0: base, exponent (63 bits each), zero fill.
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // Fields from bit 0: power_result (62 bits), zero fill.
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    psel          = 1'b0;
  logic                    penable       = 1'b0;
  logic                    pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0]   paddr         = '0;
  logic [CFG_DATA_W-1:0]   pwdata        = '0;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  // The testbench's own copy of the modulus register.
  logic [MOD_W-1:0]        active_modulus = MOD_RESET;
  // Powers still owed by the block, oldest first.
  logic [MOD_W-1:0]        pending_powers[$];

  int unsigned             error_count  = 0;
  int unsigned             cycle_count  = 0;
  int unsigned             burst_left   = 0;
  int unsigned             ready_cycles = 0;
  ready_mode_e             ready_mode   = READY_ALWAYS;
  bit [7:0]                ready_bits   = 8'h01;

  modular_exponentiation_top #(
    .OPERAND_BITS(OPERAND_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Modular product by shift-and-add doubling. Both operands are already
  // below the modulus, and the modulus fits in 62 bits, so a 64-bit sum
  // never overflows.
  function automatic logic [63:0] modular_product(input logic [63:0] a, b, m);
    logic [63:0] acc;
    logic [63:0] doubled;
    logic [63:0] multiplier;
    acc        = '0;
    doubled    = a;
    multiplier = b;
    while (multiplier != 0) begin
      if (multiplier[0]) begin
        acc = acc + doubled;
        if (acc >= m) acc = acc - m;
      end
      doubled = doubled << 1;
      if (doubled >= m) doubled = doubled - m;
      multiplier = multiplier >> 1;
    end
    return acc;
  endfunction

  // Right-to-left square-and-multiply. A zero exponent gives 1 without any
  // reduction, and a zero modulus gives 0 for every other exponent.
  function automatic logic [MOD_W-1:0] predicted_power(input logic [OPERAND_BITS-1:0] base,
                                                       input logic [OPERAND_BITS-1:0] exponent,
                                                       input logic [MOD_W-1:0] modulus);
    logic [63:0] m;
    logic [63:0] square;
    logic [63:0] running;
    logic [63:0] bits_left;
    if (exponent == 0) return MOD_W'(1);
    if (modulus == 0) return '0;
    m         = 64'(modulus);
    square    = 64'(base) % m;
    running   = 64'd1 % m;
    bits_left = 64'(exponent);
    while (bits_left != 0) begin
      if (bits_left[0]) running = modular_product(running, square, m);
      square    = modular_product(square, square, m);
      bits_left = bits_left >> 1;
    end
    return running[MOD_W-1:0];
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Offers one item to the block. The sender works in bursts: when a burst
  // is used up, tvalid drops and a random, nonzero gap follows before the
  // next burst starts, so tvalid never falls and rises within the same time
  // step. The expected power is queued at the accepting edge.
  task automatic send_power_item(input logic [OPERAND_BITS-1:0] base,
                                 input logic [OPERAND_BITS-1:0] exponent,
                                 input bit typed_in,
                                 input logic [MOD_W-1:0] typed_power);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      // Mostly short bursts, now and then a long stretch with no idling.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(1, 5);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, exponent, base};
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed_in) pending_powers.push_back(typed_power);
    else pending_powers.push_back(predicted_power(base, exponent, active_modulus));
    burst_left--;
    if (burst_left == 0) s_axis_tvalid <= 1'b0;
  endtask

  // Ends the current burst and waits until every owed result has come out,
  // which leaves the block idle since every item yields exactly one result.
  task automatic drain_results();
    if (burst_left != 0) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
    end
    while (pending_powers.size() != 0) @(posedge clk_i);
  endtask

  // APB write of the modulus: setup phase, then access phase until pready.
  // The two bits above the 62-bit register are filled at random; the block
  // is expected to drop them.
  task automatic write_modulus(input logic [MOD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MODULUS;
    pwdata  <= {2'($urandom_range(0, 3)), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    active_modulus = value;
  endtask

  // Result side: check each accepted item against the oldest expectation,
  // then pick the next value of tready. The receiver switches at random
  // between always ready, a coin toss, and a rotating pattern that is
  // never all stalls.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_powers.size() == 0) begin
        flag_error($sformatf("unexpected result power=0x%016h", m_axis_tdata[MOD_W-1:0]));
      end else begin
        if (m_axis_tdata[MOD_W-1:0] !== pending_powers[0]) begin
          flag_error($sformatf("power mismatch: expected 0x%016h, got 0x%016h",
                               pending_powers[0], m_axis_tdata[MOD_W-1:0]));
        end
        void'(pending_powers.pop_front());
      end
    end
    if (ready_cycles == 0) begin
      ready_mode   = ready_mode_e'($urandom_range(0, 2));
      ready_bits   = 8'($urandom) | 8'h01;
      ready_cycles = $urandom_range(16, 300);
    end
    ready_cycles--;
    ready_bits = {ready_bits[6:0], ready_bits[7]};
    case (ready_mode)
      READY_ALWAYS: begin
        m_axis_tready <= 1'b1;
      end
      READY_COIN: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready <= ready_bits[0];
      end
    endcase
  end

  // Watchdog for a block that hangs or never answers.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_modular_exponentiation_top: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t         directed_rows [DIRECTED_ROWS];
    logic [OPERAND_BITS-1:0] base;
    logic [OPERAND_BITS-1:0] exponent;
    logic [63:0]           random_word;
    logic [MOD_W-1:0]      modulus;
    int unsigned           width;

    // The first rows run on the modulus left by reset, 1000000007, which is
    // prime. Later rows cover a modulus of one, the largest modulus, two,
    // zero (outside the normal range, but defined), and a small prime.
    directed_rows = '{
      '{1'b0, 62'd1000000007, 63'd0, 63'd0, 1'b1, 62'd1},
      '{1'b0, 62'd1000000007, 63'h7FFF_FFFF_FFFF_FFFF, 63'd0, 1'b1, 62'd1},
      '{1'b0, 62'd1000000007, 63'd0, 63'd1, 1'b1, 62'd0},
      '{1'b0, 62'd1000000007, 63'd2, 63'd10, 1'b1, 62'd1024},
      '{1'b0, 62'd1000000007, 63'd1000000007, 63'd5, 1'b1, 62'd0},
      '{1'b0, 62'd1000000007, 63'd1000000006, 63'd2, 1'b1, 62'd1},
      '{1'b0, 62'd1000000007, 63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0, 62'd0},
      // Fermat: 3 to the power p-1 is 1 modulo a prime p.
      '{1'b0, 62'd1000000007, 63'd3, 63'd1000000006, 1'b1, 62'd1},
      // A modulus of one still gives 1 for a zero exponent.
      '{1'b1, 62'd1, 63'd5, 63'd0, 1'b1, 62'd1},
      '{1'b0, 62'd1, 63'd5, 63'd3, 1'b1, 62'd0},
      '{1'b0, 62'd1, 63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 62'd0},
      '{1'b1, 62'h3FFF_FFFF_FFFF_FFFF, 63'h3FFF_FFFF_FFFF_FFFF, 63'd1, 1'b1, 62'd0},
      '{1'b0, 62'h3FFF_FFFF_FFFF_FFFF, 63'h3FFF_FFFF_FFFF_FFFE, 63'd2, 1'b1, 62'd1},
      '{1'b0, 62'h3FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF,
        1'b0, 62'd0},
      '{1'b0, 62'h3FFF_FFFF_FFFF_FFFF, 63'd2, 63'd61, 1'b1, 62'h2000_0000_0000_0000},
      '{1'b0, 62'h3FFF_FFFF_FFFF_FFFF, 63'd2, 63'd62, 1'b1, 62'd1},
      '{1'b1, 62'd2, 63'd3, 63'd7, 1'b1, 62'd1},
      '{1'b0, 62'd2, 63'd4, 63'd1, 1'b1, 62'd0},
      // A zero modulus gives 1 for a zero exponent and 0 otherwise.
      '{1'b1, 62'd0, 63'd7, 63'd0, 1'b1, 62'd1},
      '{1'b0, 62'd0, 63'd7, 63'd9, 1'b1, 62'd0},
      '{1'b1, 62'd97, 63'd5, 63'd96, 1'b1, 62'd1},
      '{1'b0, 62'd97, 63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 62'd0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].load_modulus) begin
        drain_results();
        write_modulus(directed_rows[i].modulus);
      end
      send_power_item(directed_rows[i].base, directed_rows[i].exponent,
                      directed_rows[i].typed_in, directed_rows[i].power);
    end

    // Random phases, each under a fresh modulus whose width is chosen per
    // phase: a tiny one, a mid-sized one, a full 62-bit one, then two of
    // any width. The top bit of the chosen width is always set.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: width = $urandom_range(1, 8);
        1: width = $urandom_range(9, 40);
        2: width = MOD_W;
        default: width = $urandom_range(1, MOD_W);
      endcase
      random_word = {$urandom, $urandom};
      modulus = MOD_W'(random_word & ((64'd1 << width) - 1));
      modulus[width-1] = 1'b1;
      drain_results();
      write_modulus(modulus);

      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Bases: full-width at random, tiny, or right around the modulus.
        random_word = {$urandom, $urandom};
        case ($urandom_range(0, 3))
          0, 1: base = random_word[OPERAND_BITS-1:0];
          2: base = OPERAND_BITS'($urandom_range(0, 15));
          default: base = OPERAND_BITS'(active_modulus) + OPERAND_BITS'($urandom_range(0, 2))
                          - OPERAND_BITS'(1);
        endcase
        // Exponents are mostly short to keep the run quick; one in five
        // spans the full 63 bits, which is the slow case.
        random_word = {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0) begin
          exponent = random_word[OPERAND_BITS-1:0];
        end else begin
          width    = $urandom_range(0, 12);
          exponent = OPERAND_BITS'(random_word & ((64'd1 << width) - 1));
        end
        send_power_item(base, exponent, 1'b0, '0);
      end
    end

    drain_results();
    // Quiet cycles after the drain catch any stray result after the last one.
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_modular_exponentiation_top: PASS");
    end else begin
      $display("tb_modular_exponentiation_top: FAIL");
    end
    $finish;
  end

endmodule
